FILE: rtl/core/spq_pkg.sv
// shared types and constants for the stable priority queue
// no dependencies; imported by every module of the block
package spq_pkg;

   localparam int DEFAULT_DEPTH = 16;

   localparam int VALUE_W = 32;
   localparam int PRIO_W  = 8;
   localparam int OCC_W   = 5;
   localparam int STAT_W  = 2;

   // operation codes
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   // result status codes
   localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

   typedef struct packed {
      logic                      func;
      logic signed [VALUE_W-1:0] in_value;
      logic [PRIO_W-1:0]         in_priority;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] out_value;
      logic [PRIO_W-1:0]         out_priority;
      logic [STAT_W-1:0]         status;
      logic [OCC_W-1:0]          occupancy;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } stat_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage

FILE: rtl/core/spq_ctrl.sv
// controller state machine for the stable priority queue
// depends on spq_pkg; drives the datapath through cmd_type
module spq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  spq_pkg::stat_type stat,
   output spq_pkg::cmd_type  cmd
);
   import spq_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.commit = 1'b0;
      req_stall  = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // wait until the result register can take the new result
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/core/spq_datapath.sv
// datapath of the stable priority queue: request register, sorted cell row,
// entry count and result register; depends on spq_pkg
module spq_datapath #(
   parameter int DEPTH = spq_pkg::DEFAULT_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  spq_pkg::req_type  req_data,
   input  spq_pkg::cmd_type  cmd,
   output spq_pkg::stat_type stat,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output spq_pkg::rsp_type  rsp_data
);
   import spq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   req_type                   req_ff;
   rsp_type                   rsp_ff;
   rsp_type                   rsp_in;
   logic                      rsp_valid_ff;
   logic [CW-1:0]             count_ff;
   logic [CW-1:0]             count_in;
   logic signed [VALUE_W-1:0] slot_value_ff    [DEPTH];
   logic signed [VALUE_W-1:0] slot_value_in    [DEPTH];
   logic [PRIO_W-1:0]         slot_priority_ff [DEPTH];
   logic [PRIO_W-1:0]         slot_priority_in [DEPTH];
   logic [DEPTH-1:0]          greater;
   logic                      is_insert;
   logic                      full;
   logic                      empty;
   logic                      do_insert;
   logic                      do_remove;

   assign is_insert = (req_ff.func == FUNC_INSERT);
   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_insert = cmd.commit && is_insert && !full;
   assign do_remove = cmd.commit && !is_insert && !empty;

   // result register is free when empty or being taken this cycle
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   // request register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
   end

   // per cell: held entry with a larger priority than the new one
   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         assign greater[i] = (CW'(i) < count_ff) &&
                             (slot_priority_ff[i] > req_ff.in_priority);

         // local shift decision of each cell
         always_comb begin
            slot_value_in[i]    = slot_value_ff[i];
            slot_priority_in[i] = slot_priority_ff[i];
            if (do_insert) begin
               if (i > 0 && greater[(i > 0) ? i - 1 : 0]) begin
                  slot_value_in[i]    = slot_value_ff[(i > 0) ? i - 1 : 0];
                  slot_priority_in[i] = slot_priority_ff[(i > 0) ? i - 1 : 0];
               end else if (greater[i] || (CW'(i) == count_ff)) begin
                  slot_value_in[i]    = req_ff.in_value;
                  slot_priority_in[i] = req_ff.in_priority;
               end
            end else if (do_remove && (i < DEPTH - 1)) begin
               slot_value_in[i]    = slot_value_ff[(i < DEPTH - 1) ? i + 1 : i];
               slot_priority_in[i] = slot_priority_ff[(i < DEPTH - 1) ? i + 1 : i];
            end
         end

         always_ff @(posedge clock) begin
            slot_value_ff[i]    <= slot_value_in[i];
            slot_priority_ff[i] <= slot_priority_in[i];
         end
      end
   endgenerate

   // entry count and result
   always_comb begin
      count_in            = count_ff;
      rsp_in.out_value    = '0;
      rsp_in.out_priority = '0;
      rsp_in.status       = STAT_DONE;
      if (is_insert) begin
         if (full) begin
            rsp_in.status = STAT_FULL;
         end else begin
            count_in = count_ff + CW'(1);
         end
      end else begin
         if (empty) begin
            rsp_in.status = STAT_EMPTY;
         end else begin
            count_in            = count_ff - CW'(1);
            rsp_in.out_value    = slot_value_ff[0];
            rsp_in.out_priority = slot_priority_ff[0];
         end
      end
      rsp_in.occupancy = OCC_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/core/stable_priority_queue.sv
// top level of the stable priority queue: controller plus datapath
// depends on spq_pkg, spq_ctrl and spq_datapath
//
// usage
//   req channel: func selects insert or remove; in_value and in_priority give
//   the entry to insert. A transfer happens when req_valid is high and
//   req_stall is low. Each request gives exactly one result on the rsp channel.
//   Entries leave lowest priority number first, equal priorities in arrival
//   order. A remove on an empty queue returns the empty status, an insert into
//   a full queue is dropped with the full status.
//   flow: the controller takes a request into the request register, then
//   applies it to the cell row once the result register is free, and only
//   then takes the next request; every cell compares and shifts in parallel,
//   so the depth adds no steps to a request.
//   reset: synchronous; clears the entry count and the result valid, slots
//   hold stale data that is never read.
//   stall: a held result stays in the output register; one more request is
//   taken meanwhile and waits until the output register frees.
module stable_priority_queue #(
   parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output spq_pkg::rsp_type rsp_data
);
   import spq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // control
   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // sorted cell row and result register
   spq_datapath #(
      .DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // a request transfer is followed by a busy cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while previous one in progress");

   // a commit never overwrites a result still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("pending result lost");

   // a refused insert reports a full queue
   a_full_occupancy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STAT_FULL) |->
      (rsp_data.occupancy == OCC_W'(QUEUE_DEPTH) && rsp_data.out_value == '0))
      else $error("full status with wrong occupancy");

   // an empty remove reports zero entries and zero priority
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STAT_EMPTY) |->
      (rsp_data.occupancy == '0 && rsp_data.out_priority == '0))
      else $error("empty status with nonzero fields");

endmodule
